/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that one condition implies another on the same edge.
`define ASSERT_IMPL(label, cond, cons, msg) \
  `ASSERT_CLK(label, (cond) |-> (cons), msg)

`endif

/* rtl/lpht_pkg.sv */
// Shared constants, codes and types of the linear-probing hash table.
package lpht_pkg;

  localparam int TABLE_SIZE  = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int KEY_W       = 16;
  localparam int SLOT_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W       = $clog2(TABLE_SIZE + 1);
  localparam int ENTRY_W     = KEY_W + VALUE_WIDTH;
  localparam int MODE_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int OUT_SLOT_W  = 4;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd2;

  localparam logic [STATUS_W-1:0] STS_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] STS_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STS_FULL      = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } lpht_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } lpht_cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
  } lpht_sts_t;

endpackage

/* rtl/linear_probe_hash_table_core.sv */
// Top level of the linear-probing hash table: controller plus datapath.
//
// Pulse start while busy is low to hand in one beat (mode, key, value). The
// block walks the table one slot a cycle from the key's home slot, starting
// the home-slot read in the accept cycle, so busy stays high from the accept
// edge until the walk ends, at a pace set by the single read port of the
// table RAM. Search and modify always visit all 16 slots unless the key is
// found; insert stops at the first empty slot. The result beat appears on the
// out_ ports for exactly one cycle with out_valid, in the first cycle after
// busy falls, and the receiver cannot stall it: sample it then or lose it.
// A new start is taken in that same cycle. The table is empty after reset.
module linear_probe_hash_table_core
  import lpht_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [MODE_W-1:0]      in_mode,
  input  logic [KEY_W-1:0]       in_record_key,
  input  logic [VALUE_WIDTH-1:0] in_record_value,
  output logic                   out_valid,
  output logic [STATUS_W-1:0]    out_status,
  output logic [OUT_SLOT_W-1:0]  out_slot,
  output logic [VALUE_WIDTH-1:0] out_old_value
);

  lpht_cmd_t cmd;
  lpht_sts_t sts;

  lpht_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  lpht_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_mode        (in_mode),
    .in_record_key  (in_record_key),
    .in_record_value(in_record_value),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_old_value  (out_old_value)
  );

endmodule

/* rtl/lpht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/lpht_ctrl.sv */
// Controller state machine that sequences one table operation.
module lpht_ctrl
  import lpht_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  lpht_sts_t sts,
  output lpht_cmd_t cmd,
  output logic      busy
);

  lpht_state_t state_r;
  lpht_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.hit || sts.exhausted) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* rtl/lpht_dp.sv */
// Datapath: probe address walk, slot compare, valid bits, table RAM, result registers.
module lpht_dp
  import lpht_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  lpht_cmd_t              cmd,
  input  logic [MODE_W-1:0]      in_mode,
  input  logic [KEY_W-1:0]       in_record_key,
  input  logic [VALUE_WIDTH-1:0] in_record_value,
  output lpht_sts_t              sts,
  output logic                   out_valid,
  output logic [STATUS_W-1:0]    out_status,
  output logic [OUT_SLOT_W-1:0]  out_slot,
  output logic [VALUE_WIDTH-1:0] out_old_value
);

  logic [MODE_W-1:0]      mode_r;
  logic [KEY_W-1:0]       key_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [SLOT_W-1:0]      pos_r,      pos_nxt;
  logic [CNT_W-1:0]       cnt_r,      cnt_nxt;
  logic                   chk_r,      chk_nxt;
  logic [SLOT_W-1:0]      chk_pos_r,  chk_pos_nxt;
  logic                   chk_vld_r,  chk_vld_nxt;
  logic                   chk_last_r, chk_last_nxt;
  logic [TABLE_SIZE-1:0]  valid_r;
  logic                   out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [OUT_SLOT_W-1:0]  out_slot_r;
  logic [VALUE_WIDTH-1:0] out_old_value_r;

  logic [SLOT_W-1:0]      raddr;
  logic [CNT_W-1:0]       cnt_base;
  logic                   issue;
  logic [ENTRY_W-1:0]     rdata;
  logic [KEY_W-1:0]       rkey;
  logic [VALUE_WIDTH-1:0] rval;
  logic                   is_insert;
  logic                   is_modify;
  logic                   hit;
  logic                   we;

  assign raddr    = cmd.load ? in_record_key[SLOT_W-1:0] : pos_r;
  assign cnt_base = cmd.load ? '0 : cnt_r;
  assign issue    = (cnt_base < CNT_W'(TABLE_SIZE));

  // Issue one probe a cycle; its compare follows when the read data lands.
  always_comb begin
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    chk_nxt      = chk_r;
    chk_pos_nxt  = chk_pos_r;
    chk_vld_nxt  = chk_vld_r;
    chk_last_nxt = chk_last_r;
    if (cmd.load || cmd.step) begin
      pos_nxt      = raddr + SLOT_W'(1);
      cnt_nxt      = issue ? cnt_base + CNT_W'(1) : cnt_base;
      chk_nxt      = issue;
      chk_pos_nxt  = raddr;
      chk_vld_nxt  = valid_r[raddr];
      chk_last_nxt = (cnt_base == CNT_W'(TABLE_SIZE - 1));
    end else if (cmd.finish) begin
      chk_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r       <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      chk_r       <= chk_nxt;
      out_valid_r <= cmd.finish;
      if (we && is_insert) begin
        valid_r[chk_pos_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r  <= in_mode;
      key_r   <= in_record_key;
      value_r <= in_record_value;
    end
    pos_r      <= pos_nxt;
    cnt_r      <= cnt_nxt;
    chk_pos_r  <= chk_pos_nxt;
    chk_vld_r  <= chk_vld_nxt;
    chk_last_r <= chk_last_nxt;
    if (cmd.finish) begin
      out_slot_r <= hit ? OUT_SLOT_W'(chk_pos_r) : '0;
      out_old_value_r <= (hit && !is_insert) ? rval : '0;
      if (is_insert) begin
        out_status_r <= hit ? STS_INSERTED : STS_FULL;
      end else begin
        out_status_r <= hit ? STS_FOUND : STS_NOT_FOUND;
      end
    end
  end

  assign rkey      = rdata[VALUE_WIDTH +: KEY_W];
  assign rval      = rdata[VALUE_WIDTH-1:0];
  assign is_insert = (mode_r == MODE_INSERT);
  assign is_modify = (mode_r == MODE_MODIFY);
  assign hit       = chk_r && (is_insert ? !chk_vld_r : (chk_vld_r && (rkey == key_r)));
  assign we        = cmd.finish && hit && (is_insert || is_modify);

  assign sts.hit       = hit;
  assign sts.exhausted = chk_r && chk_last_r;

  lpht_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_SIZE)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(chk_pos_r),
    .wdata({key_r, value_r}),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_slot      = out_slot_r;
  assign out_old_value = out_old_value_r;

endmodule

/* rtl/lpht_checker.sv */
// Port-level checker for the hash table core and its bind.
`include "assert_macros.svh"

module lpht_checker
  import lpht_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_valid,
  input logic [STATUS_W-1:0]    out_status,
  input logic [OUT_SLOT_W-1:0]  out_slot,
  input logic [VALUE_WIDTH-1:0] out_old_value
);

  `ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "accepted beat did not raise busy")
  `ASSERT_CLK(a_done_result, $fell(busy) |-> out_valid, "operation ended without a result")
  `ASSERT_IMPL(a_result_idle, out_valid, !busy, "result shown while busy")
  `ASSERT_CLK(a_single_strobe, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `ASSERT_IMPL(a_old_zero,
               out_valid && (out_status != STS_FOUND),
               (out_old_value == '0) && (out_status == STS_INSERTED || out_slot == '0),
               "miss result carries data")

endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for the linear-probing hash table core.
`timescale 1ns / 100ps

module tb_top;
  import lpht_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 400;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [OUT_SLOT_W-1:0]  slot;
    logic [VALUE_WIDTH-1:0] old_value;
  } probe_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  logic [MODE_W-1:0]      in_mode;
  logic [KEY_W-1:0]       in_record_key;
  logic [VALUE_WIDTH-1:0] in_record_value;
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [OUT_SLOT_W-1:0]  out_slot;
  logic [VALUE_WIDTH-1:0] out_old_value;

  logic                   shadow_valid [TABLE_SIZE];
  logic [KEY_W-1:0]       shadow_key   [TABLE_SIZE];
  logic [VALUE_WIDTH-1:0] shadow_value [TABLE_SIZE];

  probe_result_t pending_results[$];
  int            fail_count;
  int            idle_cycles;
  int            burst_left;

  linear_probe_hash_table_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_record_key   (in_record_key),
    .in_record_value (in_record_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_old_value   (out_old_value)
  );

  always #4 clk = ~clk;

  function automatic probe_result_t apply_table_op(input logic [MODE_W-1:0] mode,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [VALUE_WIDTH-1:0] value);
    probe_result_t res;
    int            pos;
    int            hit;
    res = '0;
    hit = -1;
    pos = key % TABLE_SIZE;
    if (mode == MODE_INSERT) begin
      for (int n = 0; n < TABLE_SIZE; n++) begin
        if (hit < 0 && !shadow_valid[pos]) hit = pos;
        pos = (pos + 1) % TABLE_SIZE;
      end
      if (hit < 0) begin
        res.status = STS_FULL;
      end else begin
        shadow_valid[hit] = 1'b1;
        shadow_key[hit]   = key;
        shadow_value[hit] = value;
        res.status = STS_INSERTED;
        res.slot   = hit[OUT_SLOT_W-1:0];
      end
    end else begin
      for (int n = 0; n < TABLE_SIZE; n++) begin
        if (hit < 0 && shadow_valid[pos] && shadow_key[pos] == key) hit = pos;
        pos = (pos + 1) % TABLE_SIZE;
      end
      if (hit < 0) begin
        res.status = STS_NOT_FOUND;
      end else begin
        res.status    = STS_FOUND;
        res.slot      = hit[OUT_SLOT_W-1:0];
        res.old_value = shadow_value[hit];
        if (mode == MODE_MODIFY) shadow_value[hit] = value;
      end
    end
    return res;
  endfunction

  function automatic int table_occupancy();
    int cnt;
    cnt = 0;
    for (int i = 0; i < TABLE_SIZE; i++) if (shadow_valid[i]) cnt++;
    return cnt;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(input bit stored);
    int idx;
    if (!stored || table_occupancy() == 0) return KEY_W'($urandom_range(0, 65535));
    do idx = $urandom_range(0, TABLE_SIZE - 1); while (!shadow_valid[idx]);
    return shadow_key[idx];
  endfunction

  task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                           input logic [VALUE_WIDTH-1:0] value);
    start           <= 1'b1;
    in_mode         <= mode;
    in_record_key   <= key;
    in_record_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_table_op(mode, key, value));
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 20);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 12);
    end
  endtask

  task automatic send_paced(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
                            input logic [VALUE_WIDTH-1:0] value);
    send_beat(mode, key, value);
    pace();
  endtask

  task automatic random_beat(input int insert_pct);
    int                     pick;
    logic [MODE_W-1:0]      mode;
    logic [KEY_W-1:0]       key;
    logic [VALUE_WIDTH-1:0] value;
    pick  = $urandom_range(0, 99);
    value = $urandom();
    if (pick < insert_pct) begin
      mode = MODE_INSERT;
      key  = pick_key($urandom_range(0, 3) == 0);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      mode = MODE_SEARCH;
      else if (pick < 85) mode = MODE_MODIFY;
      else                mode = MODE_UNUSED;
      key = pick_key($urandom_range(0, 99) < 75);
    end
    send_paced(mode, key, value);
  endtask

  task automatic test_basic_ops();
    send_paced(MODE_INSERT, 16'h0000, 32'h0000_0000);
    send_paced(MODE_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_paced(MODE_SEARCH, 16'h0000, $urandom());
    send_paced(MODE_SEARCH, 16'hFFFF, $urandom());
    send_paced(MODE_MODIFY, 16'hFFFF, 32'h5A5A_A5A5);
    send_paced(MODE_SEARCH, 16'hFFFF, 32'h0000_0000);
    send_paced(MODE_SEARCH, 16'h1234, $urandom());
    send_paced(MODE_MODIFY, 16'h1234, $urandom());
    send_paced(MODE_UNUSED, 16'h0000, 32'hFFFF_FFFF);
    send_paced(MODE_SEARCH, 16'h0000, $urandom());
  endtask

  task automatic test_collisions_and_wrap();
    send_paced(MODE_INSERT, 16'h0010, $urandom());
    send_paced(MODE_INSERT, 16'hFFEF, $urandom());
    send_paced(MODE_INSERT, 16'h0000, 32'hA5A5_5A5A);
    send_paced(MODE_SEARCH, 16'h0000, $urandom());
    send_paced(MODE_MODIFY, 16'h0000, 32'hFFFF_FFFF);
    send_paced(MODE_SEARCH, 16'hFFEF, $urandom());
    send_paced(MODE_MODIFY, 16'hFFEF, $urandom());
  endtask

  task automatic test_random_fill();
    while (table_occupancy() < TABLE_SIZE) random_beat(50);
  endtask

  task automatic test_full_table();
    send_paced(MODE_INSERT, KEY_W'($urandom_range(0, 65535)), $urandom());
    send_paced(MODE_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
    send_paced(MODE_SEARCH, 16'h7FFE, $urandom());
    send_paced(MODE_MODIFY, 16'h7FFE, $urandom());
  endtask

  task automatic test_random_traffic(input int count);
    for (int i = 0; i < count; i++) random_beat(15);
  endtask

  always @(posedge clk) begin
    probe_result_t exp_res;
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no expectation: status %0d slot %0d old_value %h",
                 out_status, out_slot, out_old_value);
          fail_count++;
        end else begin
          exp_res = pending_results.pop_front();
          if (out_status !== exp_res.status) begin
            $error("status expected %0d actual %0d", exp_res.status, out_status);
            fail_count++;
          end
          if (out_slot !== exp_res.slot) begin
            $error("slot expected %0d actual %0d", exp_res.slot, out_slot);
            fail_count++;
          end
          if (out_old_value !== exp_res.old_value) begin
            $error("old_value expected %h actual %h", exp_res.old_value, out_old_value);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_mode         = MODE_INSERT;
    in_record_key   = '0;
    in_record_value = '0;
    burst_left      = 0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_value[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_collisions_and_wrap();
    test_random_fill();
    test_full_table();
    test_random_traffic(1960);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_ctrl.sv
rtl/lpht_dp.sv
rtl/linear_probe_hash_table_core.sv
rtl/lpht_checker.sv
tb/tb_top.sv
